/* rtl/stb_pkg.sv */
`timescale 1ns / 1ps
package stb_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int TIME_BITS = 32;
  localparam int QDEPTH    = 2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  localparam logic [2:0] KIND_REGISTER = 3'd0;
  localparam logic [2:0] KIND_START    = 3'd1;
  localparam logic [2:0] KIND_MODIFY   = 3'd2;
  localparam logic [2:0] KIND_STOP     = 3'd3;
  localparam logic [2:0] KIND_DELETE   = 3'd4;
  localparam logic [2:0] KIND_DEL_ALL  = 3'd5;
  localparam logic [2:0] KIND_TICK     = 3'd6;

  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_EXPIRY = 2'd1;
  localparam logic [1:0] RK_DONE   = 2'd2;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_NOT_FOUND = 1'b1;

  typedef enum logic [2:0] {
    OP_REG     = 3'd0,
    OP_START   = 3'd1,
    OP_MODIFY  = 3'd2,
    OP_STOP    = 3'd3,
    OP_DELETE  = 3'd4,
    OP_DEL_ALL = 3'd5,
    OP_TICK    = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef struct packed {
    op_t   op;
    slot_t slot;
    logic  slot_ok;
    time_t timeout;
    logic  start_active;
    logic  one_shot;
    logic  has_handler;
    time_t tnow;
  } cmd_t;

endpackage

/* rtl/soft_timer_bank_top.sv */
`timescale 1ns / 1ps
// An operation's transaction is written into the command queue; the idle executor pops
// it and registers its status strobe. A tick leaves idle, scans the slots in order
// (8 slots; the scan ends at the first slot freed), then strobes the done item.
// Throughput: one operation per cycle while not busy; a full 2-entry queue sets busy.
// Reset (rst, synchronous): all slots free, queue empty, no strobe.
module soft_timer_bank_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     kind,
  input  stb_pkg::slot_t slot,
  input  stb_pkg::time_t new_timeout,
  input  logic           start_active,
  input  logic           one_shot,
  input  logic           has_handler,
  input  stb_pkg::time_t now,
  output logic           strobe,
  output logic [1:0]     result_kind,
  output logic           status,
  output stb_pkg::slot_t event_slot,
  output logic           last
);
  import stb_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  stb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .slot         (slot),
    .new_timeout  (new_timeout),
    .start_active (start_active),
    .one_shot     (one_shot),
    .has_handler  (has_handler),
    .now          (now),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  stb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .strobe      (strobe),
    .result_kind (result_kind),
    .status      (status),
    .event_slot  (event_slot),
    .last        (last)
  );

  a_rst_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

  a_done_form: assert property (@(posedge clk) disable iff (rst)
    strobe && result_kind == RK_DONE |-> last && status == ST_OK && event_slot == '0)
    else $error("malformed done item");

  a_expiry_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result_kind == RK_EXPIRY |-> !last && status == ST_OK)
    else $error("expiry marked last");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result_kind == RK_STATUS |-> last)
    else $error("status item not last");

endmodule

/* rtl/stb_front.sv */
`timescale 1ns / 1ps
module stb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    kind,
  input  stb_pkg::slot_t slot,
  input  stb_pkg::time_t new_timeout,
  input  logic          start_active,
  input  logic          one_shot,
  input  logic          has_handler,
  input  stb_pkg::time_t now,
  output logic          q_valid,
  output stb_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import stb_pkg::*;

  cmd_t        fifo [QDEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  cmd_t        dec;
  logic        push;

  always_comb begin
    case (kind)
      KIND_REGISTER: dec.op = OP_REG;
      KIND_START:    dec.op = OP_START;
      KIND_MODIFY:   dec.op = OP_MODIFY;
      KIND_STOP:     dec.op = OP_STOP;
      KIND_DELETE:   dec.op = OP_DELETE;
      KIND_DEL_ALL:  dec.op = OP_DEL_ALL;
      KIND_TICK:     dec.op = OP_TICK;
      default:       dec.op = OP_NOP;
    endcase
    dec.slot         = slot;
    dec.slot_ok      = (SLOT_W + 1)'(slot) < (SLOT_W + 1)'(NUM_SLOTS);
    dec.timeout      = new_timeout;
    dec.start_active = start_active;
    dec.one_shot     = one_shot;
    dec.has_handler  = has_handler;
    dec.tnow         = now;
  end

  assign busy    = (count == 2'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/stb_back.sv */
`timescale 1ns / 1ps
module stb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  stb_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          strobe,
  output logic [1:0]    result_kind,
  output logic          status,
  output stb_pkg::slot_t event_slot,
  output logic          last
);
  import stb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state;
  slot_t                idx;
  time_t                tick_now;
  logic [NUM_SLOTS-1:0] in_use;
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] oneshot;
  logic [NUM_SLOTS-1:0] deact;
  logic [NUM_SLOTS-1:0] handler;
  time_t                tmo   [NUM_SLOTS];
  time_t                start_t [NUM_SLOTS];

  time_t elapsed;
  logic  fire;
  logic  act_after;
  logic  report;
  logic  free_slot;
  logic  used;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign used  = q_cmd.slot_ok && in_use[q_cmd.slot];

  always_comb begin
    elapsed   = tick_now - start_t[idx];
    fire      = in_use[idx] && active[idx] && (elapsed >= tmo[idx]);
    act_after = active[idx] && !(fire && oneshot[idx]);
    report    = fire && handler[idx] && !deact[idx];
    free_slot = in_use[idx] && !act_after && (oneshot[idx] || deact[idx]);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_cmd.op)
        OP_REG: begin
          if (q_cmd.slot_ok) begin
            tmo[q_cmd.slot]     <= q_cmd.timeout;
            start_t[q_cmd.slot] <= q_cmd.tnow;
          end
        end
        OP_START, OP_MODIFY: begin
          if (used) begin
            start_t[q_cmd.slot] <= q_cmd.tnow;
            if (q_cmd.op == OP_MODIFY) begin
              tmo[q_cmd.slot] <= q_cmd.timeout;
            end
          end
        end
        default: ;
      endcase
    end else if (state == S_SCAN && fire) begin
      start_t[idx] <= tick_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      in_use  <= '0;
      active  <= '0;
      oneshot <= '0;
      deact   <= '0;
      handler <= '0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            result_kind <= RK_STATUS;
            status      <= ST_OK;
            event_slot  <= q_cmd.slot;
            last        <= 1'b1;
            case (q_cmd.op)
              OP_REG: begin
                strobe <= 1'b1;
                if (q_cmd.slot_ok) begin
                  in_use[q_cmd.slot]  <= 1'b1;
                  active[q_cmd.slot]  <= q_cmd.start_active;
                  oneshot[q_cmd.slot] <= q_cmd.one_shot;
                  handler[q_cmd.slot] <= q_cmd.has_handler;
                  deact[q_cmd.slot]   <= 1'b0;
                end else begin
                  status <= ST_NOT_FOUND;
                end
              end
              OP_START, OP_MODIFY, OP_STOP, OP_DELETE: begin
                strobe <= 1'b1;
                if (used) begin
                  active[q_cmd.slot] <= (q_cmd.op == OP_START) || (q_cmd.op == OP_MODIFY);
                  if (q_cmd.op == OP_DELETE) begin
                    deact[q_cmd.slot] <= 1'b1;
                  end
                end else begin
                  status <= ST_NOT_FOUND;
                end
              end
              OP_DEL_ALL: begin
                strobe     <= 1'b1;
                event_slot <= '0;
                active     <= active & ~in_use;
                deact      <= deact | in_use;
              end
              OP_TICK: begin
                tick_now <= q_cmd.tnow;
                idx      <= '0;
                state    <= S_SCAN;
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          strobe      <= report;
          result_kind <= RK_EXPIRY;
          status      <= ST_OK;
          event_slot  <= idx;
          last        <= 1'b0;
          if (fire && oneshot[idx]) begin
            active[idx] <= 1'b0;
          end
          if (free_slot) begin
            in_use[idx]  <= 1'b0;
            oneshot[idx] <= 1'b0;
            deact[idx]   <= 1'b0;
            handler[idx] <= 1'b0;
            state        <= S_DONE;
          end else if (idx == SLOT_W'(NUM_SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          strobe      <= 1'b1;
          result_kind <= RK_DONE;
          status      <= ST_OK;
          event_slot  <= '0;
          last        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import stb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 190;

  typedef struct packed {
    logic [2:0] kind;
    slot_t      slot;
    time_t      tmo;
    logic       run;
    logic       once;
    logic       notify;
    time_t      tnow;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0] rkind;
    logic       stat;
    slot_t      eslot;
    logic       fin;
  } timer_result_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       start        = 1'b0;
  logic       busy;
  logic [2:0] kind         = '0;
  slot_t      slot         = '0;
  time_t      new_timeout  = '0;
  logic       start_active = 1'b0;
  logic       one_shot     = 1'b0;
  logic       has_handler  = 1'b0;
  time_t      now          = '0;
  logic       strobe;
  logic [1:0] result_kind;
  logic       status;
  slot_t      event_slot;
  logic       last;

  logic  bank_in_use [NUM_SLOTS];
  logic  bank_active [NUM_SLOTS];
  logic  bank_once   [NUM_SLOTS];
  logic  bank_dead   [NUM_SLOTS];
  logic  bank_notify [NUM_SLOTS];
  time_t bank_tmo    [NUM_SLOTS];
  time_t bank_t0     [NUM_SLOTS];

  timer_result_t pending_results[$];
  int            mismatches = 0;
  bit            no_idle    = 1'b1;
  time_t         sys_now;

  soft_timer_bank_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .slot         (slot),
    .new_timeout  (new_timeout),
    .start_active (start_active),
    .one_shot     (one_shot),
    .has_handler  (has_handler),
    .now          (now),
    .strobe       (strobe),
    .result_kind  (result_kind),
    .status       (status),
    .event_slot   (event_slot),
    .last         (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void queue_result(logic [1:0] rk, logic st, slot_t sl, logic fin);
    pending_results.push_back(timer_result_t'{rk, st, sl, fin});
  endfunction

  function automatic void update_timer_bank(timer_cmd_t c);
    logic  hit;
    time_t elapsed;
    hit = bank_in_use[c.slot];
    case (c.kind)
      KIND_REGISTER: begin
        bank_in_use[c.slot] = 1'b1;
        bank_active[c.slot] = c.run;
        bank_once[c.slot]   = c.once;
        bank_notify[c.slot] = c.notify;
        bank_dead[c.slot]   = 1'b0;
        bank_tmo[c.slot]    = c.tmo;
        bank_t0[c.slot]     = c.tnow;
        queue_result(RK_STATUS, ST_OK, c.slot, 1'b1);
      end
      KIND_START, KIND_MODIFY: begin
        if (hit) begin
          bank_active[c.slot] = 1'b1;
          bank_t0[c.slot]     = c.tnow;
          if (c.kind == KIND_MODIFY) bank_tmo[c.slot] = c.tmo;
        end
        queue_result(RK_STATUS, hit ? ST_OK : ST_NOT_FOUND, c.slot, 1'b1);
      end
      KIND_STOP, KIND_DELETE: begin
        if (hit) begin
          bank_active[c.slot] = 1'b0;
          if (c.kind == KIND_DELETE) bank_dead[c.slot] = 1'b1;
        end
        queue_result(RK_STATUS, hit ? ST_OK : ST_NOT_FOUND, c.slot, 1'b1);
      end
      KIND_DEL_ALL: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank_in_use[i]) begin
            bank_active[i] = 1'b0;
            bank_dead[i]   = 1'b1;
          end
        end
        queue_result(RK_STATUS, ST_OK, '0, 1'b1);
      end
      KIND_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (bank_in_use[i]) begin
            if (bank_active[i]) begin
              elapsed = c.tnow - bank_t0[i];
              if (elapsed >= bank_tmo[i]) begin
                bank_t0[i] = c.tnow;
                if (bank_once[i]) bank_active[i] = 1'b0;
                if (bank_notify[i] && !bank_dead[i])
                  queue_result(RK_EXPIRY, ST_OK, slot_t'(i), 1'b0);
              end
            end
            // first finished slot is freed and ends the scan
            if (!bank_active[i] && (bank_once[i] || bank_dead[i])) begin
              bank_in_use[i] = 1'b0;
              bank_once[i]   = 1'b0;
              bank_dead[i]   = 1'b0;
              bank_notify[i] = 1'b0;
              break;
            end
          end
        end
        queue_result(RK_DONE, ST_OK, '0, 1'b1);
      end
      default: begin
        queue_result(RK_STATUS, ST_OK, c.slot, 1'b1);
      end
    endcase
  endfunction

  task automatic send_cmd(timer_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    kind         <= c.kind;
    slot         <= c.slot;
    new_timeout  <= c.tmo;
    start_active <= c.run;
    one_shot     <= c.once;
    has_handler  <= c.notify;
    now          <= c.tnow;
    do @(posedge clk); while (busy);
    update_timer_bank(c);
  endtask

  task automatic issue(logic [2:0] k, slot_t s, time_t t, logic r, logic o, logic h,
                       time_t n);
    send_cmd(timer_cmd_t'{k, s, t, r, o, h, n});
  endtask

  task automatic test_empty_bank();
    no_idle = 1'b1;
    issue(KIND_TICK,    3'd0, '0,           1'b0, 1'b0, 1'b0, '0);
    issue(KIND_START,   3'd3, 32'd5,        1'b1, 1'b1, 1'b1, 32'd1);
    issue(KIND_MODIFY,  3'd7, '1,           1'b0, 1'b1, 1'b0, '1);
    issue(KIND_STOP,    3'd0, '0,           1'b1, 1'b0, 1'b1, 32'd2);
    issue(KIND_DELETE,  3'd5, 32'hA5A5A5A5, 1'b0, 1'b0, 1'b0, 32'h5A5A5A5A);
    issue(KIND_DEL_ALL, 3'd2, '0,           1'b0, 1'b0, 1'b0, '0);
    issue(OP_NOP,       3'd6, '1,           1'b1, 1'b1, 1'b1, '1);
  endtask

  task automatic test_timer_lifecycle();
    no_idle = 1'b0;
    issue(KIND_REGISTER, 3'd0, '0,           1'b1, 1'b0, 1'b1, '1);
    issue(KIND_REGISTER, 3'd7, '1,           1'b1, 1'b1, 1'b1, '0);
    issue(KIND_REGISTER, 3'd1, 32'd5,        1'b0, 1'b0, 1'b0, '0);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, '0);
    issue(KIND_START,    3'd1, '0,           1'b0, 1'b0, 1'b0, 32'd10);
    issue(KIND_MODIFY,   3'd1, 32'd3,        1'b0, 1'b0, 1'b0, 32'd10);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'd13);
    issue(KIND_STOP,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'd13);
    issue(KIND_DELETE,   3'd1, '0,           1'b0, 1'b0, 1'b0, 32'd13);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'd14);
    issue(KIND_REGISTER, 3'd2, 32'd2,        1'b1, 1'b1, 1'b1, 32'd20);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'd22);
    // elapsed time wraps through zero
    issue(KIND_REGISTER, 3'd7, 32'h20,       1'b1, 1'b1, 1'b1, 32'hFFFFFFF0);
    issue(KIND_REGISTER, 3'd0, 32'd4,        1'b1, 1'b0, 1'b1, 32'hFFFFFFF0);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'h10);
    // restarted after delete: runs but stays silent
    issue(KIND_REGISTER, 3'd3, 32'd1,        1'b1, 1'b0, 1'b1, 32'h10);
    issue(KIND_DELETE,   3'd3, '0,           1'b0, 1'b0, 1'b0, 32'h10);
    issue(KIND_START,    3'd3, '0,           1'b0, 1'b0, 1'b0, 32'h10);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'h20);
    issue(KIND_DEL_ALL,  3'd5, '0,           1'b0, 1'b0, 1'b0, 32'h20);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'h30);
    issue(KIND_TICK,     3'd0, '0,           1'b0, 1'b0, 1'b0, 32'h40);
  endtask

  task automatic test_random_traffic();
    int         issued;
    int         pick;
    timer_cmd_t c;
    issued  = 0;
    sys_now = $urandom;
    while (issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      pick     = $urandom_range(0, 99);
      c.slot   = slot_t'($urandom_range(0, NUM_SLOTS - 1));
      c.tmo    = ($urandom_range(0, 9) == 0) ? time_t'($urandom)
                                             : time_t'($urandom_range(0, 24));
      c.run    = $urandom_range(0, 4) != 0;
      c.once   = 1'($urandom_range(0, 1));
      c.notify = $urandom_range(0, 5) != 0;
      c.tnow   = sys_now;
      if (pick < 24) c.kind = KIND_REGISTER;
      else if (pick < 34) c.kind = KIND_START;
      else if (pick < 44) c.kind = KIND_MODIFY;
      else if (pick < 51) c.kind = KIND_STOP;
      else if (pick < 57) c.kind = KIND_DELETE;
      else if (pick < 59) c.kind = KIND_DEL_ALL;
      else if (pick < 61) c.kind = OP_NOP;
      else begin
        c.kind = KIND_TICK;
        if ($urandom_range(0, 19) == 0) sys_now = $urandom;
        else sys_now = sys_now + time_t'($urandom_range(0, 12));
        c.tnow = sys_now;
      end
      send_cmd(c);
      if (c.kind != OP_NOP) issued++;
    end
  endtask

  always @(posedge clk) begin : check_results
    timer_result_t got;
    timer_result_t want;
    if (!rst && strobe) begin
      got = timer_result_t'{result_kind, status, event_slot, last};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d status %0d slot %0d last %0d",
                   got.rkind, got.stat, got.eslot, got.fin);
      end else begin
        want = pending_results.pop_front();
        if (got.rkind !== want.rkind || got.stat !== want.stat ||
            got.eslot !== want.eslot || got.fin !== want.fin) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected kind %0d status %0d slot %0d last %0d",
                     want.rkind, want.stat, want.eslot, want.fin);
            $display("          got      kind %0d status %0d slot %0d last %0d",
                     got.rkind, got.stat, got.eslot, got.fin);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst == 1'b0);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || strobe) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      bank_in_use[i] = 1'b0;
      bank_active[i] = 1'b0;
      bank_once[i]   = 1'b0;
      bank_dead[i]   = 1'b0;
      bank_notify[i] = 1'b0;
      bank_tmo[i]    = '0;
      bank_t0[i]     = '0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_empty_bank();
    test_timer_lifecycle();
    test_random_traffic();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/stb_pkg.sv
rtl/stb_front.sv
rtl/stb_back.sv
rtl/soft_timer_bank_top.sv
tb/sv/tb.sv
